// ----- hdl/cramer_pkg.sv -----
// Shared types and constants for the 2x2 Cramer solver.
package cramer_pkg;

  localparam int unsigned CoefW = 16;
  localparam int unsigned DetW  = 33;
  localparam int unsigned NumW  = DetW + 16;
  localparam int unsigned MagW  = NumW;
  localparam int unsigned SolW  = 32;
  localparam int unsigned KindW = 2;

  localparam logic [KindW-1:0] KIND_INCONSISTENT = 2'd0;
  localparam logic [KindW-1:0] KIND_UNIQUE       = 2'd1;
  localparam logic [KindW-1:0] KIND_INFINITE     = 2'd2;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             x_neg;
    logic             y_neg;
  } div_ctl_t;

endpackage

// ----- hdl/cramer_det.sv -----
// Two-stage determinant unit: products, then differences and classification.
module cramer_det (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic signed [cramer_pkg::CoefW-1:0]     a1,
  input  logic signed [cramer_pkg::CoefW-1:0]     b1,
  input  logic signed [cramer_pkg::CoefW-1:0]     c1,
  input  logic signed [cramer_pkg::CoefW-1:0]     a2,
  input  logic signed [cramer_pkg::CoefW-1:0]     b2,
  input  logic signed [cramer_pkg::CoefW-1:0]     c2,
  output logic                                    out_valid,
  output cramer_pkg::div_ctl_t                    ctl,
  output logic [cramer_pkg::MagW-1:0]             mag_x,
  output logic [cramer_pkg::MagW-1:0]             mag_y,
  output logic [cramer_pkg::MagW-1:0]             mag_w
);
  localparam int unsigned PW = 2 * cramer_pkg::CoefW;
  localparam int unsigned DW = cramer_pkg::DetW;
  localparam int unsigned MW = cramer_pkg::MagW;

  logic              v1;
  logic signed [PW-1:0] p_a1b2, p_b1a2, p_c1b2, p_b1c2, p_a1c2, p_c1a2;
  logic signed [DW-1:0] w, wx, wy;
  logic signed [MW-1:0] nx, ny;
  cramer_pkg::div_ctl_t ctl_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_a1b2 <= a1 * b2;
      p_b1a2 <= b1 * a2;
      p_c1b2 <= c1 * b2;
      p_b1c2 <= b1 * c2;
      p_a1c2 <= a1 * c2;
      p_c1a2 <= c1 * a2;
      ctl    <= ctl_next;
      mag_x  <= nx[MW-1] ? MW'(-nx) : nx;
      mag_y  <= ny[MW-1] ? MW'(-ny) : ny;
      mag_w  <= w[DW-1] ? MW'(-MW'(w)) : MW'(w);
    end
  end

  always_comb begin
    w  = DW'(p_a1b2) - DW'(p_b1a2);
    wx = DW'(p_c1b2) - DW'(p_b1c2);
    wy = DW'(p_a1c2) - DW'(p_c1a2);
    nx = {wx, 16'd0};
    ny = {wy, 16'd0};
    ctl_next.x_neg = wx[DW-1] ^ w[DW-1];
    ctl_next.y_neg = wy[DW-1] ^ w[DW-1];
    if (w != '0)
      ctl_next.kind = cramer_pkg::KIND_UNIQUE;
    else if (wx == '0 && wy == '0)
      ctl_next.kind = cramer_pkg::KIND_INFINITE;
    else
      ctl_next.kind = cramer_pkg::KIND_INCONSISTENT;
  end
endmodule

// ----- hdl/cramer_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, for x and y.
module cramer_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  cramer_pkg::div_ctl_t           ctl_in,
  input  logic [cramer_pkg::MagW-1:0]    mag_x,
  input  logic [cramer_pkg::MagW-1:0]    mag_y,
  input  logic [cramer_pkg::MagW-1:0]    mag_w,
  output logic                           out_valid,
  output cramer_pkg::div_ctl_t           ctl_out,
  output logic [cramer_pkg::MagW-1:0]    quo_x,
  output logic [cramer_pkg::MagW-1:0]    quo_y
);
  localparam int unsigned N = cramer_pkg::MagW;

  // Stage s holds the partial remainder, the dividend bits not yet used
  // (shifted into the quotient register as quotient bits come out).
  logic                 v   [N+1];
  cramer_pkg::div_ctl_t c   [N+1];
  logic [N-1:0]         d   [N+1];
  logic [N:0]           rx  [N+1];
  logic [N:0]           ry  [N+1];
  logic [N-1:0]         qx  [N+1];
  logic [N-1:0]         qy  [N+1];

  assign v[0]  = in_valid;
  assign c[0]  = ctl_in;
  assign d[0]  = mag_w;
  assign rx[0] = '0;
  assign ry[0] = '0;
  assign qx[0] = mag_x;
  assign qy[0] = mag_y;

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [N:0] tx, ty;
    always_comb begin
      tx = {rx[s][N-1:0], qx[s][N-1]};
      ty = {ry[s][N-1:0], qy[s][N-1]};
    end
    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else if (en) v[s+1] <= v[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        c[s+1] <= c[s];
        d[s+1] <= d[s];
        if (tx >= {1'b0, d[s]}) begin
          rx[s+1] <= tx - {1'b0, d[s]};
          qx[s+1] <= {qx[s][N-2:0], 1'b1};
        end else begin
          rx[s+1] <= tx;
          qx[s+1] <= {qx[s][N-2:0], 1'b0};
        end
        if (ty >= {1'b0, d[s]}) begin
          ry[s+1] <= ty - {1'b0, d[s]};
          qy[s+1] <= {qy[s][N-2:0], 1'b1};
        end else begin
          ry[s+1] <= ty;
          qy[s+1] <= {qy[s][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[N];
  assign ctl_out   = c[N];
  assign quo_x     = qx[N];
  assign quo_y     = qy[N];
endmodule

// ----- hdl/cramer_2x2_solver_unit.sv -----
// Cramer's-rule 2x2 solver top level: determinants, divider, sign and clamp.
//
// Usage: a request on the input channel (coef_valid/coef_ready) carries the
// six Q7.8 coefficients of a1x+b1y=c1 and a2x+b2y=c2. Each request yields
// exactly one result on the output channel (sol_valid/sol_ready): kind
// (0 inconsistent, 1 unique, 2 infinitely many), sol_x and sol_y in Q15.16
// truncated toward zero, and saturated when either was clamped.
// From acceptance to sol_valid a request passes two stages of determinant
// arithmetic, one stage per quotient bit of the restoring divider, and one
// output stage. Throughput is one request per cycle while the output is not
// stalled; the divider array processes both quotients side by side.
// The whole pipeline advances together; when the receiver holds sol_ready
// low with a result waiting, the pipeline freezes and coef_ready drops, so
// nothing is lost or repeated. Reset clears all valid bits; results in
// flight are discarded.
module cramer_2x2_solver_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 coef_valid,
  output logic                                 coef_ready,
  input  logic signed [cramer_pkg::CoefW-1:0]  coef_a1,
  input  logic signed [cramer_pkg::CoefW-1:0]  coef_b1,
  input  logic signed [cramer_pkg::CoefW-1:0]  coef_c1,
  input  logic signed [cramer_pkg::CoefW-1:0]  coef_a2,
  input  logic signed [cramer_pkg::CoefW-1:0]  coef_b2,
  input  logic signed [cramer_pkg::CoefW-1:0]  coef_c2,
  output logic                                 sol_valid,
  input  logic                                 sol_ready,
  output logic [cramer_pkg::KindW-1:0]         kind,
  output logic signed [cramer_pkg::SolW-1:0]   sol_x,
  output logic signed [cramer_pkg::SolW-1:0]   sol_y,
  output logic                                 saturated
);
  localparam int unsigned MW = cramer_pkg::MagW;
  localparam int unsigned SW = cramer_pkg::SolW;

  logic                 en;
  logic                 dv, qv;
  cramer_pkg::div_ctl_t dctl, qctl;
  logic [MW-1:0]        mx, my, mw, qx, qy;
  logic [SW-1:0]        rx, ry;
  logic                 satx, saty;

  assign en         = !sol_valid || sol_ready;
  assign coef_ready = en;

  cramer_det u_det (
    .clk, .rst, .en,
    .in_valid (coef_valid),
    .a1 (coef_a1), .b1 (coef_b1), .c1 (coef_c1),
    .a2 (coef_a2), .b2 (coef_b2), .c2 (coef_c2),
    .out_valid (dv), .ctl (dctl),
    .mag_x (mx), .mag_y (my), .mag_w (mw)
  );

  cramer_div u_div (
    .clk, .rst, .en,
    .in_valid (dv), .ctl_in (dctl),
    .mag_x (mx), .mag_y (my), .mag_w (mw),
    .out_valid (qv), .ctl_out (qctl),
    .quo_x (qx), .quo_y (qy)
  );

  // Apply the sign to a magnitude and clamp to 32 bits.
  function automatic logic [SW:0] clamp(input logic [MW-1:0] m, input logic neg);
    logic [SW:0] r;
    if (neg) begin
      if (m > MW'(33'h080000000)) r = {1'b1, 1'b1, {(SW-1){1'b0}}};
      else r = {1'b0, SW'(-m)};
    end else begin
      if (m > MW'(32'h7fffffff)) r = {1'b1, 1'b0, {(SW-1){1'b1}}};
      else r = {1'b0, m[SW-1:0]};
    end
    return r;
  endfunction

  always_comb begin
    {satx, rx} = clamp(qx, qctl.x_neg);
    {saty, ry} = clamp(qy, qctl.y_neg);
  end

  always_ff @(posedge clk) begin
    if (rst) sol_valid <= 1'b0;
    else if (en) sol_valid <= qv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind <= qctl.kind;
      if (qctl.kind == cramer_pkg::KIND_UNIQUE) begin
        sol_x     <= rx;
        sol_y     <= ry;
        saturated <= satx | saty;
      end else begin
        sol_x     <= '0;
        sol_y     <= '0;
        saturated <= 1'b0;
      end
    end
  end
endmodule

// ----- verif/tb.sv -----
// Testbench for the 2x2 Cramer solver: queued requests, random idling, self-checking.
`timescale 1ns / 1ps

module tb;
  localparam int unsigned CW = cramer_pkg::CoefW;

  typedef struct packed {
    logic signed [cramer_pkg::CoefW-1:0] a1, b1, c1, a2, b2, c2;
  } coef_set_t;

  typedef struct packed {
    logic [cramer_pkg::KindW-1:0]       kind;
    logic signed [cramer_pkg::SolW-1:0] x;
    logic signed [cramer_pkg::SolW-1:0] y;
    logic                               sat;
  } solution_t;

  localparam int NumRandom = 1530;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic coef_valid = 1'b0;
  logic coef_ready;
  logic signed [cramer_pkg::CoefW-1:0] coef_a1 = '0, coef_b1 = '0, coef_c1 = '0;
  logic signed [cramer_pkg::CoefW-1:0] coef_a2 = '0, coef_b2 = '0, coef_c2 = '0;
  logic sol_valid;
  logic sol_ready = 1'b0;
  logic [cramer_pkg::KindW-1:0] kind;
  logic signed [cramer_pkg::SolW-1:0] sol_x, sol_y;
  logic saturated;

  coef_set_t pending_systems[$];
  solution_t expected_solutions[$];
  coef_set_t cur_system;
  int total_systems = 0;
  int sent_systems = 0;
  int solved_count = 0;
  int send_gap = 0;
  int recv_hold = 0;
  bit long_hold_done = 0;
  int errors = 0;

  cramer_2x2_solver_unit i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [cramer_pkg::SolW-1:0] fixed_quotient(
      longint num, longint den, inout logic clamped);
    longint q;
    q = (num * 65536) / den;
    if (q > 64'sd2147483647) begin
      q = 64'sd2147483647;
      clamped = 1'b1;
    end else if (q < -64'sd2147483648) begin
      q = -64'sd2147483648;
      clamped = 1'b1;
    end
    return q[cramer_pkg::SolW-1:0];
  endfunction

  function automatic solution_t solve_system(coef_set_t s);
    longint w, wx, wy;
    logic clamped;
    solution_t r;
    w  = longint'(s.a1) * longint'(s.b2) - longint'(s.b1) * longint'(s.a2);
    wx = longint'(s.c1) * longint'(s.b2) - longint'(s.b1) * longint'(s.c2);
    wy = longint'(s.a1) * longint'(s.c2) - longint'(s.c1) * longint'(s.a2);
    r = '0;
    clamped = 1'b0;
    if (w == 0) begin
      r.kind = (wx == 0 && wy == 0) ? cramer_pkg::KIND_INFINITE
                                    : cramer_pkg::KIND_INCONSISTENT;
    end else begin
      r.kind = cramer_pkg::KIND_UNIQUE;
      r.x = fixed_quotient(wx, w, clamped);
      r.y = fixed_quotient(wy, w, clamped);
      r.sat = clamped;
    end
    return r;
  endfunction

  function automatic coef_set_t make_set(int a1, int b1, int c1, int a2, int b2, int c2);
    coef_set_t s;
    s.a1 = CW'(a1); s.b1 = CW'(b1); s.c1 = CW'(c1);
    s.a2 = CW'(a2); s.b2 = CW'(b2); s.c2 = CW'(c2);
    return s;
  endfunction

  function automatic logic signed [cramer_pkg::CoefW-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return -16'sd32768;
      1: return -16'sd1;
      2: return 16'sd0;
      3: return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic coef_set_t random_set();
    coef_set_t s;
    int k;
    int mode;
    mode = $urandom_range(0, 9);
    s = $urandom ^ {$urandom, $urandom, $urandom};
    if (mode inside {[5:6]}) begin
      s.a1 = CW'($urandom_range(0, 2047) - 1024);
      s.b1 = CW'($urandom_range(0, 2047) - 1024);
      s.c1 = CW'($urandom_range(0, 2047) - 1024);
      s.a2 = CW'($urandom_range(0, 2047) - 1024);
      s.b2 = CW'($urandom_range(0, 2047) - 1024);
      s.c2 = CW'($urandom_range(0, 2047) - 1024);
    end else if (mode inside {[7:8]}) begin
      // Proportional rows make the main determinant vanish.
      k = $urandom_range(0, 200) - 100;
      s.a1 = CW'($urandom_range(0, 400) - 200);
      s.b1 = CW'($urandom_range(0, 400) - 200);
      s.c1 = CW'($urandom_range(0, 400) - 200);
      s.a2 = CW'(k * s.a1);
      s.b2 = CW'(k * s.b1);
      if ($urandom_range(0, 1) != 0) s.c2 = CW'(k * s.c1);
      else s.c2 = CW'($urandom_range(0, 65535));
    end else if (mode == 9) begin
      s.a1 = pick_extreme(); s.b1 = pick_extreme(); s.c1 = pick_extreme();
      s.a2 = pick_extreme(); s.b2 = pick_extreme(); s.c2 = pick_extreme();
    end
    return s;
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      coef_valid <= 1'b0;
    end else begin
      if (coef_valid && coef_ready) begin
        expected_solutions.push_back(solve_system(cur_system));
        sent_systems++;
      end
      if (!coef_valid || coef_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          coef_valid <= 1'b0;
        end else if (pending_systems.size() > 0) begin
          cur_system = pending_systems.pop_front();
          coef_a1 <= cur_system.a1; coef_b1 <= cur_system.b1; coef_c1 <= cur_system.c1;
          coef_a2 <= cur_system.a2; coef_b2 <= cur_system.b2; coef_c2 <= cur_system.c2;
          coef_valid <= 1'b1;
          // Every third block of 200 requests goes back to back.
          send_gap = ((sent_systems / 200) % 3 == 2) ? 0 : $urandom_range(0, 8);
        end else begin
          coef_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    solution_t exp_sol;
    if (rst) begin
      sol_ready <= 1'b0;
    end else begin
      if (sol_valid && sol_ready) begin
        if (expected_solutions.size() == 0) begin
          $error("unexpected result: kind=%0d x=%0d y=%0d", kind, sol_x, sol_y);
          errors++;
        end else begin
          exp_sol = expected_solutions.pop_front();
          if (kind !== exp_sol.kind) begin
            $error("kind: expected %0d, actual %0d", exp_sol.kind, kind);
            errors++;
          end
          if (sol_x !== exp_sol.x) begin
            $error("sol_x: expected %0d, actual %0d", exp_sol.x, sol_x);
            errors++;
          end
          if (sol_y !== exp_sol.y) begin
            $error("sol_y: expected %0d, actual %0d", exp_sol.y, sol_y);
            errors++;
          end
          if (saturated !== exp_sol.sat) begin
            $error("saturated: expected %0d, actual %0d", exp_sol.sat, saturated);
            errors++;
          end
        end
        solved_count++;
        if (solved_count == 300 && !long_hold_done) begin
          // One long stall so the pipeline fills and input ready drops.
          long_hold_done = 1;
          recv_hold = 200;
        end else if ((solved_count / 250) % 3 == 1) begin
          recv_hold = 0;
        end else begin
          recv_hold = $urandom_range(0, 8);
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        sol_ready <= 1'b0;
      end else begin
        sol_ready <= 1'b1;
      end
    end
  end

  initial begin
    pending_systems.push_back(make_set(0, 0, 0, 0, 0, 0));
    pending_systems.push_back(make_set(1, 2, 3, 2, 4, 6));
    pending_systems.push_back(make_set(1, 1, 1, 1, 1, 2));
    pending_systems.push_back(make_set(1, 0, 1, 1, 0, 2));
    pending_systems.push_back(make_set(0, 1, 1, 0, 1, 2));
    pending_systems.push_back(make_set(256, 0, 512, 0, 256, -768));
    pending_systems.push_back(make_set(1, 0, 32767, 0, 1, -32768));
    pending_systems.push_back(make_set(1, 0, -32768, 0, 1, 32767));
    pending_systems.push_back(make_set(1, 1, 32767, 1, -1, -32768));
    pending_systems.push_back(make_set(32767, 32767, 32767, 32767, 32767, 32767));
    pending_systems.push_back(make_set(-32768, -32768, -32768, -32768, -32768, -32768));
    pending_systems.push_back(make_set(-32768, 32767, -32768, 32767, -32768, 32767));
    pending_systems.push_back(make_set(32767, -32768, 32767, -32768, 32767, -32768));
    pending_systems.push_back(make_set(-32768, 0, 32767, 0, -32768, -32768));
    pending_systems.push_back(make_set(-1, -1, -1, 1, -1, 1));
    pending_systems.push_back(make_set(3, 7, -5, 11, -2, 9));
    pending_systems.push_back(make_set(0, 1, 0, 1, 0, 0));
    pending_systems.push_back(make_set(-1, 0, 0, 0, -1, 0));
    pending_systems.push_back(make_set(2, 4, 0, 1, 2, 0));
    pending_systems.push_back(make_set(32767, 1, 1, 32767, 2, -1));
    for (int i = 0; i < NumRandom; i++) pending_systems.push_back(random_set());
    total_systems = pending_systems.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (sent_systems < total_systems || expected_solutions.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
